// File: rtl/core/aan_pkg.sv
// Shared constants of the auto-ranging angle normalizer.
// Used by the top level; depends on nothing.
`default_nettype none

package aan_pkg;

  localparam int unsigned SCALE_BITS       = 9;
  localparam logic [SCALE_BITS-1:0] FULL_SCALE_RESET = 9'd180;

endpackage

`default_nettype wire

// File: rtl/core/autorange_angle_normalizer_unit.sv
// Auto-ranging angle normalizer: running min/max store, multiplier and bit-serial divider.
// Depends on aan_pkg.
`default_nettype none

// Usage:
// The slave stream carries one item per frame: CHANNELS samples packed in
// s_axis_tdata_i. The master stream returns one item per frame: CHANNELS
// angles with FRACTION_BITS fraction bits packed in m_axis_tdata_o.
// The full scale register is written through cfg_we_i and cfg_wdata_i; the user
// must do so only while idle, unchecked by the block; it resets to 180 degrees.
// Per-channel minimum and maximum live in a small synchronous memory. Each
// channel takes a read, an update and write-back, one multiply, and a
// restoring divide of one quotient bit per cycle. One frame is worked on at
// a time; the next can be accepted in the same cycle as the result is offered.
// A finished result sits in an output register; the next frame is accepted
// while it waits, and only the hand-over of a later result stalls until the
// receiver takes it.
// Reset clears the valid bits of the memory, so every channel starts with an
// empty range, and drops the master stream valid.
module autorange_angle_normalizer_unit #(
  parameter int unsigned CHANNELS      = 6,
  parameter int unsigned SAMPLE_BITS   = 10,
  parameter int unsigned FRACTION_BITS = 8,
  localparam int unsigned ANGLE_BITS   = aan_pkg::SCALE_BITS + FRACTION_BITS,
  localparam int unsigned IN_DATA_W    = ((CHANNELS * SAMPLE_BITS + 7) / 8) * 8,
  localparam int unsigned OUT_DATA_W   = ((CHANNELS * ANGLE_BITS + 7) / 8) * 8
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                s_axis_tvalid_i,
  output logic                                     s_axis_tready_o,
  // Fields from bit 0 up: sample_0, sample_1, ... sample_(CHANNELS-1).
  input  wire logic [IN_DATA_W-1:0]                s_axis_tdata_i,
  output logic                                     m_axis_tvalid_o,
  input  wire logic                                m_axis_tready_i,
  // Fields from bit 0 up: angle_0, angle_1, ... angle_(CHANNELS-1).
  output logic [OUT_DATA_W-1:0]                    m_axis_tdata_o,
  input  wire logic                                cfg_we_i,
  input  wire logic [aan_pkg::SCALE_BITS-1:0]      cfg_wdata_i
);
  import aan_pkg::*;

  localparam int unsigned CH_W    = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int unsigned MIN_W   = SAMPLE_BITS + 1;
  localparam int unsigned ENT_W   = MIN_W + SAMPLE_BITS;
  localparam int unsigned PROD_W  = SAMPLE_BITS + SCALE_BITS;
  localparam int unsigned NUM_W   = PROD_W + FRACTION_BITS;
  localparam int unsigned CNT_W   = $clog2(ANGLE_BITS);
  localparam logic [CH_W-1:0]  LAST_CH = CH_W'(CHANNELS - 1);
  localparam logic [CNT_W-1:0] LAST_BIT = CNT_W'(ANGLE_BITS - 1);
  localparam logic [MIN_W-1:0] MIN_RESET = MIN_W'(1) << SAMPLE_BITS;

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_READ  = 3'd1;
  localparam logic [2:0] ST_CALC  = 3'd2;
  localparam logic [2:0] ST_MUL   = 3'd3;
  localparam logic [2:0] ST_LOAD  = 3'd4;
  localparam logic [2:0] ST_DIV   = 3'd5;
  localparam logic [2:0] ST_STORE = 3'd6;
  localparam logic [2:0] ST_DONE  = 3'd7;

  logic [2:0]                 state_q, state_d;
  logic [CH_W-1:0]            ch_q;
  logic [CNT_W-1:0]           cnt_q;
  logic [SCALE_BITS-1:0]      fs_q;
  logic [SAMPLE_BITS-1:0]     samp_q [CHANNELS];
  logic [ANGLE_BITS-1:0]      res_q  [CHANNELS];
  logic [ANGLE_BITS-1:0]      out_q  [CHANNELS];
  logic                       m_valid_q;

  logic [ENT_W-1:0]           mem_q [CHANNELS];
  logic [ENT_W-1:0]           rd_q;
  logic [CHANNELS-1:0]        ent_valid_q;
  logic                       rd_valid_q;

  logic [SAMPLE_BITS-1:0]     diff_q, span_q;
  logic                       zero_q;
  logic [PROD_W-1:0]          prod_q;
  logic [SAMPLE_BITS-1:0]     rem_q;
  logic [ANGLE_BITS-1:0]      low_q, quot_q;

  logic [SAMPLE_BITS-1:0]     x;
  logic [MIN_W-1:0]           lo_old, lo_new;
  logic [SAMPLE_BITS-1:0]     hi_old, hi_new;
  logic [NUM_W-1:0]           num;
  logic [SAMPLE_BITS:0]       trial;
  logic                       qbit;
  logic                       in_acc, out_free;

  assign in_acc   = s_axis_tvalid_i && s_axis_tready_o;
  assign out_free = !m_valid_q || m_axis_tready_i;
  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign m_axis_tvalid_o = m_valid_q;

  always_comb begin
    m_axis_tdata_o = '0;
    for (int i = 0; i < CHANNELS; i++) begin
      m_axis_tdata_o[i*ANGLE_BITS +: ANGLE_BITS] = out_q[i];
    end
  end

  assign x      = samp_q[ch_q];
  assign lo_old = rd_valid_q ? rd_q[ENT_W-1 -: MIN_W] : MIN_RESET;
  assign hi_old = rd_valid_q ? rd_q[SAMPLE_BITS-1:0] : '0;
  assign lo_new = (MIN_W'(x) < lo_old) ? MIN_W'(x) : lo_old;
  assign hi_new = (x > hi_old) ? x : hi_old;
  assign num    = NUM_W'(prod_q) << FRACTION_BITS;
  assign trial  = {rem_q, low_q[ANGLE_BITS-1]};
  assign qbit   = (trial >= {1'b0, span_q});

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:  if (in_acc) state_d = ST_READ;
      ST_READ:  state_d = ST_CALC;
      ST_CALC:  state_d = ST_MUL;
      ST_MUL:   state_d = ST_LOAD;
      ST_LOAD:  state_d = ST_DIV;
      ST_DIV:   if (cnt_q == '0) state_d = ST_STORE;
      ST_STORE: state_d = (ch_q == LAST_CH) ? ST_DONE : ST_READ;
      ST_DONE:  if (out_free) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      ch_q        <= '0;
      cnt_q       <= '0;
      fs_q        <= FULL_SCALE_RESET;
      m_valid_q   <= 1'b0;
      ent_valid_q <= '0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        fs_q <= cfg_wdata_i;
      end
      if (state_q == ST_CALC) begin
        ent_valid_q[ch_q] <= 1'b1;
      end
      if (in_acc) begin
        ch_q <= '0;
      end else if (state_q == ST_STORE && ch_q != LAST_CH) begin
        ch_q <= ch_q + 1'b1;
      end
      if (state_q == ST_LOAD) begin
        cnt_q <= LAST_BIT;
      end else if (state_q == ST_DIV) begin
        cnt_q <= cnt_q - 1'b1;
      end
      if (state_q == ST_DONE && out_free) begin
        m_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  // Min/max memory: one read port and one write port, read data registered.
  always_ff @(posedge clk_i) begin
    if (state_q == ST_READ) begin
      rd_q       <= mem_q[ch_q];
      rd_valid_q <= ent_valid_q[ch_q];
    end
    if (state_q == ST_CALC) begin
      mem_q[ch_q] <= {lo_new, hi_new};
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      for (int i = 0; i < CHANNELS; i++) begin
        samp_q[i] <= s_axis_tdata_i[i*SAMPLE_BITS +: SAMPLE_BITS];
      end
    end
    if (state_q == ST_CALC) begin
      diff_q <= x - lo_new[SAMPLE_BITS-1:0];
      span_q <= hi_new - lo_new[SAMPLE_BITS-1:0];
      zero_q <= (MIN_W'(hi_new) <= lo_new);
    end
    if (state_q == ST_MUL) begin
      prod_q <= PROD_W'(diff_q) * PROD_W'(fs_q);
    end
    if (state_q == ST_LOAD) begin
      rem_q  <= num[NUM_W-1 -: SAMPLE_BITS];
      low_q  <= num[ANGLE_BITS-1:0];
      quot_q <= '0;
    end
    if (state_q == ST_DIV) begin
      rem_q  <= qbit ? SAMPLE_BITS'(trial - {1'b0, span_q}) : trial[SAMPLE_BITS-1:0];
      low_q  <= low_q << 1;
      quot_q <= {quot_q[ANGLE_BITS-2:0], qbit};
    end
    if (state_q == ST_STORE) begin
      res_q[ch_q] <= zero_q ? '0 : quot_q;
    end
    if (state_q == ST_DONE && out_free) begin
      out_q <= res_q;
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/aan_checker.sv
// Port-level checks for the auto-ranging angle normalizer, bound to its top level.
// Depends on autorange_angle_normalizer_unit.
`default_nettype none

module aan_checker #(
  parameter int unsigned OUT_DATA_W = 104
) (
  input wire logic                  clk_i,
  input wire logic                  rst_ni,
  input wire logic                  s_axis_tvalid_i,
  input wire logic                  s_axis_tready_o,
  input wire logic                  m_axis_tvalid_o,
  input wire logic                  m_axis_tready_i,
  input wire logic [OUT_DATA_W-1:0] m_axis_tdata_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o && $stable(m_axis_tdata_o))
    else $error("Stalled output item changed or dropped.");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid_i && s_axis_tready_o |=> !s_axis_tready_o)
    else $error("Input ready stayed high after an item was accepted.");

  a_result_ends_frame: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid_o) |-> s_axis_tready_o)
    else $error("Result presented while a frame is still in work.");

  a_no_quick_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid_i && s_axis_tready_o |=> ##1 !$rose(m_axis_tvalid_o))
    else $error("Result appeared too soon after an item was accepted.");

endmodule

bind autorange_angle_normalizer_unit aan_checker #(
  .OUT_DATA_W(OUT_DATA_W)
) u_aan_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .s_axis_tvalid_i (s_axis_tvalid_i),
  .s_axis_tready_o (s_axis_tready_o),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o)
);

`default_nettype wire
